// ----- rtl/eci_pkg.sv -----
package eci_pkg;

  localparam int FB        = 16;
  localparam int VAL_W     = 32;
  localparam int TAB_DEPTH = 256;
  localparam int TAB_LOG   = $clog2(TAB_DEPTH);
  localparam int FR_BITS   = FB - TAB_LOG;
  localparam int TAB_W     = FB + 2;
  localparam int ARG_W     = FB + 4;
  localparam int K_W       = ARG_W - FB;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [FB:0]      ONE     = (FB + 1)'(1) << FB;
  localparam logic [FB:0]      HALF    = (FB + 1)'(1) << (FB - 1);
  localparam logic [ARG_W-1:0] TEN_ONE = ARG_W'(10) << FB;
  localparam logic [TAB_W-1:0] TWO_ONE = TAB_W'(2) << FB;

  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_LN2     = 64'sd744261118;

  typedef enum logic [3:0] {
    MODE_LINEAR      = 4'd0,
    MODE_SINE_IN     = 4'd1,
    MODE_SINE_OUT    = 4'd2,
    MODE_SINE_INOUT  = 4'd3,
    MODE_CUBIC_IN    = 4'd4,
    MODE_CUBIC_OUT   = 4'd5,
    MODE_CUBIC_INOUT = 4'd6,
    MODE_EXPO_IN     = 4'd7,
    MODE_EXPO_OUT    = 4'd8,
    MODE_EXPO_INOUT  = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    KIND_LIN,
    KIND_SINE,
    KIND_CUBE,
    KIND_POW,
    KIND_CONST
  } kind_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] present_value;
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] goal_value;
    logic [FB:0]             progress;
    logic [3:0]              ease_mode;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] eased_value;
    logic                    snapped;
  } out_t;

  typedef struct packed {
    kind_t                   kind;
    logic [ARG_W-1:0]        arg;
    logic [TAB_W-1:0]        base;
    logic                    sub;
    logic                    pre_shr1;
    logic                    pre_shl2;
    logic                    post_shr1;
    logic                    snap;
    logic signed [VAL_W-1:0] start;
    logic signed [VAL_W-1:0] goal;
  } job_t;

  typedef logic [TAB_W-1:0] tab_t [0:TAB_DEPTH];

  function automatic logic [TAB_W-1:0] q30_to_fb(longint v);
    if (v <= 0) return '0;
    return TAB_W'((v + (64'sd1 <<< (29 - FB))) >>> (30 - FB));
  endfunction

  function automatic tab_t build_sine();
    tab_t t;
    logic [63:0] x;
    logic [63:0] mag;
    longint sum;
    logic [TAB_W-1:0] s;
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      x = 64'(Q30_HALF_PI * longint'(i) / TAB_DEPTH);
      mag = x;
      sum = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        mag = (((mag * x) >> 30) * x) >> 30;
        mag = mag / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      s = q30_to_fb(sum);
      if (s > TAB_W'(ONE)) s = TAB_W'(ONE);
      t[i] = s;
    end
    t[0] = '0;
    t[TAB_DEPTH] = TAB_W'(ONE);
    return t;
  endfunction

  function automatic tab_t build_exp2();
    tab_t t;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      y = 64'(Q30_LN2 * longint'(i) / TAB_DEPTH);
      term = 64'd1 << 30;
      sum = term;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        sum = sum + term;
      end
      t[i] = q30_to_fb(longint'(sum));
    end
    t[0] = TAB_W'(ONE);
    t[TAB_DEPTH] = TWO_ONE;
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_sine();
  localparam tab_t EXP2_TAB = build_exp2();

endpackage

// ----- rtl/eci_front.sv -----
module eci_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  eci_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output eci_pkg::job_t push_job
);

  logic [eci_pkg::FB:0]        f;
  logic [eci_pkg::ARG_W-1:0]   fa;
  logic [eci_pkg::ARG_W-1:0]   one_a;
  logic [eci_pkg::ARG_W-1:0]   f_x10;
  logic [eci_pkg::ARG_W-1:0]   f_x20;
  eci_pkg::job_t               job_nxt;
  eci_pkg::job_t               job_r;
  logic                        valid_r;

  always_comb begin
    f = (in_data.progress > eci_pkg::ONE) ? eci_pkg::ONE : in_data.progress;
    fa = eci_pkg::ARG_W'(f);
    one_a = eci_pkg::ARG_W'(eci_pkg::ONE);
    f_x10 = fa * eci_pkg::ARG_W'(10);
    f_x20 = fa * eci_pkg::ARG_W'(20);
    job_nxt = '0;
    job_nxt.kind = eci_pkg::KIND_LIN;
    job_nxt.arg = fa;
    job_nxt.snap = (in_data.present_value == in_data.goal_value);
    job_nxt.start = in_data.start_value;
    job_nxt.goal = in_data.goal_value;
    unique case (in_data.ease_mode)
      eci_pkg::MODE_SINE_IN: begin
        job_nxt.kind = eci_pkg::KIND_SINE;
        job_nxt.arg = one_a - fa;
        job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
        job_nxt.sub = 1'b1;
      end
      eci_pkg::MODE_SINE_OUT: begin
        job_nxt.kind = eci_pkg::KIND_SINE;
      end
      eci_pkg::MODE_SINE_INOUT: begin
        job_nxt.kind = eci_pkg::KIND_SINE;
        job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
        job_nxt.post_shr1 = 1'b1;
        if (f <= eci_pkg::HALF) begin
          job_nxt.arg = one_a - (fa << 1);
          job_nxt.sub = 1'b1;
        end else begin
          job_nxt.arg = (fa << 1) - one_a;
        end
      end
      eci_pkg::MODE_CUBIC_IN: begin
        job_nxt.kind = eci_pkg::KIND_CUBE;
      end
      eci_pkg::MODE_CUBIC_OUT: begin
        job_nxt.kind = eci_pkg::KIND_CUBE;
        job_nxt.arg = one_a - fa;
        job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
        job_nxt.sub = 1'b1;
      end
      eci_pkg::MODE_CUBIC_INOUT: begin
        job_nxt.kind = eci_pkg::KIND_CUBE;
        if (f < eci_pkg::HALF) begin
          job_nxt.pre_shl2 = 1'b1;
        end else begin
          job_nxt.arg = (one_a << 1) - (fa << 1);
          job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
          job_nxt.sub = 1'b1;
          job_nxt.pre_shr1 = 1'b1;
        end
      end
      eci_pkg::MODE_EXPO_IN: begin
        if (f == '0) begin
          job_nxt.kind = eci_pkg::KIND_CONST;
        end else begin
          job_nxt.kind = eci_pkg::KIND_POW;
          job_nxt.arg = eci_pkg::TEN_ONE - f_x10;
        end
      end
      eci_pkg::MODE_EXPO_OUT: begin
        job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
        if (f == eci_pkg::ONE) begin
          job_nxt.kind = eci_pkg::KIND_CONST;
        end else begin
          job_nxt.kind = eci_pkg::KIND_POW;
          job_nxt.arg = f_x10;
          job_nxt.sub = 1'b1;
        end
      end
      eci_pkg::MODE_EXPO_INOUT: begin
        if (f == '0) begin
          job_nxt.kind = eci_pkg::KIND_CONST;
        end else if (f == eci_pkg::ONE) begin
          job_nxt.kind = eci_pkg::KIND_CONST;
          job_nxt.base = eci_pkg::TAB_W'(eci_pkg::ONE);
        end else if (f < eci_pkg::HALF) begin
          job_nxt.kind = eci_pkg::KIND_POW;
          job_nxt.arg = eci_pkg::TEN_ONE - f_x20;
          job_nxt.post_shr1 = 1'b1;
        end else begin
          job_nxt.kind = eci_pkg::KIND_POW;
          job_nxt.arg = f_x20 - eci_pkg::TEN_ONE;
          job_nxt.base = eci_pkg::TWO_ONE;
          job_nxt.sub = 1'b1;
          job_nxt.post_shr1 = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ----- rtl/eci_queue.sv -----
module eci_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  eci_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output eci_pkg::job_t pop_job
);

  eci_pkg::job_t               mem_r [eci_pkg::QDEPTH];
  logic [eci_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [eci_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [eci_pkg::QPTR_W:0]    cnt_r;
  logic                        push;
  logic                        pop;

  assign push_ready = (cnt_r != (eci_pkg::QPTR_W + 1)'(eci_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job = mem_r[rd_ptr_r];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/eci_back.sv -----
module eci_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  eci_pkg::job_t pop_job,
  output logic          out_valid,
  input  logic          out_ready,
  output eci_pkg::out_t out_data
);

  localparam int TW   = eci_pkg::TAB_W;
  localparam int FB   = eci_pkg::FB;
  localparam int SQ_W = 2 * FB + 2;
  localparam int IP_W = TW + eci_pkg::FR_BITS;
  localparam int CB_W = (FB + 2) + (FB + 1);
  localparam int DF_W = eci_pkg::VAL_W + 1;
  localparam int PR_W = DF_W + TW;
  localparam int SM_W = PR_W + 1;

  typedef struct packed {
    logic                            snap;
    logic signed [eci_pkg::VAL_W-1:0] start;
    logic signed [eci_pkg::VAL_W-1:0] goal;
  } tail_t;

  typedef struct packed {
    logic [TW-1:0] base;
    logic          sub;
    logic          pre_shr1;
    logic          pre_shl2;
    logic          post_shr1;
  } post_t;

  typedef struct packed {
    eci_pkg::kind_t              kind;
    logic [TW-1:0]               a;
    logic [TW-1:0]               dlt;
    logic [eci_pkg::FR_BITS-1:0] fr;
    logic [eci_pkg::K_W-1:0]     k;
    logic                        rzero;
    logic [FB:0]                 x;
    logic [SQ_W-1:0]             sq;
    post_t                       post;
    tail_t                       tail;
  } s1_t;

  typedef struct packed {
    eci_pkg::kind_t          kind;
    logic [TW-1:0]           a;
    logic [IP_W-1:0]         ip;
    logic [eci_pkg::K_W-1:0] k;
    logic                    rzero;
    logic [FB:0]             x;
    logic [CB_W-1:0]         cb;
    post_t                   post;
    tail_t                   tail;
  } s2_t;

  typedef struct packed {
    logic [FB:0]             e;
    logic signed [DF_W-1:0]  diff;
    tail_t                   tail;
  } s3_t;

  typedef struct packed {
    logic signed [PR_W-1:0]  prod;
    tail_t                   tail;
  } s4_t;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  s1_t  s1_nxt, s1_r;
  s2_t  s2_nxt, s2_r;
  s3_t  s3_nxt, s3_r;
  s4_t  s4_nxt, s4_r;
  eci_pkg::out_t out_nxt, out_r;

  logic [FB:0]          p;
  logic [eci_pkg::TAB_LOG:0] idx, idx1;
  logic [TW-1:0]        ta, tb;
  logic [TW-1:0]        lk, v;
  logic [TW+1:0]        vp;
  logic signed [TW+2:0] r, rh;
  logic signed [PR_W-1:0] q;
  logic signed [SM_W-1:0] sum;

  assign en = !out_valid_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // table lookup and first cube product
  always_comb begin
    if (pop_job.kind == eci_pkg::KIND_POW) begin
      p = eci_pkg::ONE - {1'b0, pop_job.arg[FB-1:0]};
    end else begin
      p = pop_job.arg[FB:0];
    end
    idx = p[FB:eci_pkg::FR_BITS];
    idx1 = (idx == (eci_pkg::TAB_LOG + 1)'(eci_pkg::TAB_DEPTH)) ? idx : idx + 1'b1;
    if (pop_job.kind == eci_pkg::KIND_POW) begin
      ta = eci_pkg::EXP2_TAB[idx];
      tb = eci_pkg::EXP2_TAB[idx1];
    end else begin
      ta = eci_pkg::SINE_TAB[idx];
      tb = eci_pkg::SINE_TAB[idx1];
    end
    s1_nxt.kind = pop_job.kind;
    s1_nxt.a = ta;
    s1_nxt.dlt = (tb > ta) ? tb - ta : '0;
    s1_nxt.fr = p[eci_pkg::FR_BITS-1:0];
    s1_nxt.k = pop_job.arg[eci_pkg::ARG_W-1:FB];
    s1_nxt.rzero = (pop_job.arg[FB-1:0] == '0);
    s1_nxt.x = pop_job.arg[FB:0];
    s1_nxt.sq = SQ_W'(pop_job.arg[FB:0]) * SQ_W'(pop_job.arg[FB:0]);
    s1_nxt.post.base = pop_job.base;
    s1_nxt.post.sub = pop_job.sub;
    s1_nxt.post.pre_shr1 = pop_job.pre_shr1;
    s1_nxt.post.pre_shl2 = pop_job.pre_shl2;
    s1_nxt.post.post_shr1 = pop_job.post_shr1;
    s1_nxt.tail.snap = pop_job.snap;
    s1_nxt.tail.start = pop_job.start;
    s1_nxt.tail.goal = pop_job.goal;
  end

  // interpolation product and second cube product
  always_comb begin
    s2_nxt.kind = s1_r.kind;
    s2_nxt.a = s1_r.a;
    s2_nxt.ip = IP_W'(s1_r.dlt) * IP_W'(s1_r.fr);
    s2_nxt.k = s1_r.k;
    s2_nxt.rzero = s1_r.rzero;
    s2_nxt.x = s1_r.x;
    s2_nxt.cb = CB_W'(s1_r.sq[SQ_W-1:FB]) * CB_W'(s1_r.x);
    s2_nxt.post = s1_r.post;
    s2_nxt.tail = s1_r.tail;
  end

  // easing factor and goal minus start difference
  always_comb begin
    lk = s2_r.a + TW'(s2_r.ip >> eci_pkg::FR_BITS);
    unique case (s2_r.kind)
      eci_pkg::KIND_SINE: v = lk;
      eci_pkg::KIND_CUBE: v = TW'(s2_r.cb >> FB);
      eci_pkg::KIND_POW: begin
        if (s2_r.rzero) v = TW'(eci_pkg::ONE) >> s2_r.k;
        else v = lk >> (s2_r.k + 1'b1);
      end
      eci_pkg::KIND_CONST: v = '0;
      default: v = TW'(s2_r.x);
    endcase
    if (s2_r.post.pre_shl2) vp = {v, 2'b00};
    else if (s2_r.post.pre_shr1) vp = (TW + 2)'(v >> 1);
    else vp = (TW + 2)'(v);
    if (s2_r.post.sub) r = $signed({3'b000, s2_r.post.base}) - $signed({1'b0, vp});
    else r = $signed({3'b000, s2_r.post.base}) + $signed({1'b0, vp});
    rh = s2_r.post.post_shr1 ? (r >>> 1) : r;
    if (rh < 0) s3_nxt.e = '0;
    else if (rh > $signed((TW + 3)'(eci_pkg::ONE))) s3_nxt.e = eci_pkg::ONE;
    else s3_nxt.e = rh[FB:0];
    s3_nxt.diff = DF_W'(s2_r.tail.goal) - DF_W'(s2_r.tail.start);
    s3_nxt.tail = s2_r.tail;
  end

  always_comb begin
    s4_nxt.prod = PR_W'(s3_r.diff) * $signed(PR_W'({1'b0, s3_r.e}));
    s4_nxt.tail = s3_r.tail;
  end

  // floor scale, add and saturate, or snap to the goal
  always_comb begin
    q = s4_r.prod >>> FB;
    sum = SM_W'(s4_r.tail.start) + SM_W'(q);
    out_nxt.snapped = s4_r.tail.snap;
    if (s4_r.tail.snap) begin
      out_nxt.eased_value = s4_r.tail.goal;
    end else if ((sum[SM_W-1:eci_pkg::VAL_W-1] == '0) ||
                 (sum[SM_W-1:eci_pkg::VAL_W-1] == '1)) begin
      out_nxt.eased_value = sum[eci_pkg::VAL_W-1:0];
    end else if (sum[SM_W-1]) begin
      out_nxt.eased_value = {1'b1, {(eci_pkg::VAL_W - 1){1'b0}}};
    end else begin
      out_nxt.eased_value = {1'b0, {(eci_pkg::VAL_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= pop_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/easing_curve_interpolator.sv -----
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | in_data  (eci_pkg::in_t)
// out_    | output    | out_valid / out_ready | out_data (eci_pkg::out_t)
//
// one transaction per cycle sustained while out_ready stays high; out_valid follows the input
// accept through the input register, queue write, four datapath stages, output register
// synchronous active-low reset clears the valid bits, queue pointers and queue count only
// output stall freezes the datapath stages; the input register and the
// four-entry queue keep taking transactions until the queue fills
module easing_curve_interpolator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  eci_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output eci_pkg::out_t out_data
);

  logic          push_valid;
  logic          push_ready;
  eci_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  eci_pkg::job_t pop_job;

  eci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  eci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  eci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 450;
  localparam int QUIET_ITEMS    = 60;

  class tween_scoreboard;
    logic [63:0]   sine_q[0:256];
    logic [63:0]   exp2_q[0:256];
    eci_pkg::out_t pending_results[$];
    int            mismatches;

    function new();
      build_curves();
      mismatches = 0;
    endfunction

    function logic [63:0] q30_round(longint v);
      if (v <= 0) return 64'd0;
      return (64'(v) + 64'd8192) >> 14;
    endfunction

    function void build_curves();
      logic [63:0] x, mag, y, term, acc;
      longint      total;
      for (int i = 0; i <= 256; i++) begin
        x = 64'(longint'(1686629713) * i / 256);
        mag = x;
        total = longint'(x);
        for (int n = 1; n <= 10; n++) begin
          mag = (((mag * x) >> 30) * x) >> 30;
          mag = mag / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) total = total - longint'(mag);
          else total = total + longint'(mag);
        end
        sine_q[i] = q30_round(total);
        if (sine_q[i] > 64'd65536) sine_q[i] = 64'd65536;
        y = 64'(longint'(744261118) * i / 256);
        term = 64'd1 << 30;
        acc = term;
        for (int n = 1; n <= 14; n++) begin
          term = ((term * y) >> 30) / 64'(n);
          acc = acc + term;
        end
        exp2_q[i] = q30_round(longint'(acc));
      end
      sine_q[0] = 64'd0;
      sine_q[256] = 64'd65536;
      exp2_q[0] = 64'd65536;
      exp2_q[256] = 64'd131072;
    endfunction

    function logic [63:0] interp(bit use_sine, logic [63:0] p);
      logic [63:0] pos, idx, fr, a, b;
      if (p > 64'd65536) p = 64'd65536;
      pos = p * 256;
      idx = pos >> 16;
      fr = pos & 64'hFFFF;
      if (idx >= 256) return use_sine ? sine_q[256] : exp2_q[256];
      a = use_sine ? sine_q[idx] : exp2_q[idx];
      b = use_sine ? sine_q[idx + 1] : exp2_q[idx + 1];
      if (b <= a) return a;
      return a + (((b - a) * fr) >> 16);
    endfunction

    function logic [63:0] cubed(logic [63:0] x);
      return (((x * x) >> 16) * x) >> 16;
    endfunction

    function logic [63:0] inv_pow2(logic [63:0] m);
      logic [63:0] k, r;
      k = m >> 16;
      r = m & 64'hFFFF;
      if (r == 0) return (k >= 63) ? 64'd0 : (64'd65536 >> k);
      if (k + 1 >= 63) return 64'd0;
      return interp(0, 64'd65536 - r) >> (k + 1);
    endfunction

    function logic [63:0] ease_factor(logic [63:0] f, logic [3:0] mode);
      logic [63:0] one, half, e;
      one = 64'd65536;
      half = 64'd32768;
      case (mode)
        eci_pkg::MODE_SINE_IN: e = one - interp(1, one - f);
        eci_pkg::MODE_SINE_OUT: e = interp(1, f);
        eci_pkg::MODE_SINE_INOUT: begin
          if (f <= half) e = (one - interp(1, one - 2 * f)) >> 1;
          else e = (one + interp(1, 2 * f - one)) >> 1;
        end
        eci_pkg::MODE_CUBIC_IN: e = cubed(f);
        eci_pkg::MODE_CUBIC_OUT: e = one - cubed(one - f);
        eci_pkg::MODE_CUBIC_INOUT: begin
          if (f < half) e = 4 * cubed(f);
          else e = one - (cubed(2 * one - 2 * f) >> 1);
        end
        eci_pkg::MODE_EXPO_IN: e = (f == 0) ? 64'd0 : inv_pow2(10 * (one - f));
        eci_pkg::MODE_EXPO_OUT: e = (f == one) ? one : one - inv_pow2(10 * f);
        eci_pkg::MODE_EXPO_INOUT: begin
          if (f == 0) e = 0;
          else if (f == one) e = one;
          else if (f < half) e = inv_pow2(10 * one - 20 * f) >> 1;
          else e = (2 * one - inv_pow2(20 * f - 10 * one)) >> 1;
        end
        default: e = f;
      endcase
      if (e > one) e = one;
      return e;
    endfunction

    function eci_pkg::out_t eased_result(eci_pkg::in_t d);
      eci_pkg::out_t r;
      logic [63:0]   f;
      longint        prod, total;
      if (d.present_value == d.goal_value) begin
        r.eased_value = d.goal_value;
        r.snapped = 1'b1;
        return r;
      end
      f = 64'(d.progress);
      if (f > 64'd65536) f = 64'd65536;
      prod = (longint'(d.goal_value) - longint'(d.start_value))
             * longint'(ease_factor(f, d.ease_mode));
      total = longint'(d.start_value) + (prod >>> 16);
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      r.eased_value = 32'(total);
      r.snapped = 1'b0;
      return r;
    endfunction

    function void note_input(eci_pkg::in_t d);
      pending_results.push_back(eased_result(d));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(eci_pkg::out_t got);
      eci_pkg::out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected transaction %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.eased_value !== want.eased_value)
        report($sformatf("eased_value got %h want %h", got.eased_value, want.eased_value));
      if (got.snapped !== want.snapped)
        report($sformatf("snapped got %b want %b", got.snapped, want.snapped));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  eci_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  eci_pkg::out_t out_data;
  bit            quiet = 0;
  int            idle_cycles = 0;
  tween_scoreboard sb = new();

  always #6 clk = ~clk;

  easing_curve_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 10);
      end
      repeat (n) @(posedge clk);
    end
  end

  task send(eci_pkg::in_t d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(d);
  endtask

  function logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function logic [16:0] pick_progress();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'd32768;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    eci_pkg::in_t d;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode code at one progress point, inout modes at both ends, wide spans, snap, clamp
    for (int m = 0; m < 16; m++) begin
      d.present_value = 32'sd5;
      d.start_value = (m % 2 == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      d.goal_value = (m % 2 == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      d.progress = (m < 10) ? 17'(m * 7282) : 17'h1FFFF;
      d.ease_mode = 4'(m);
      send(d);
    end
    for (int m = eci_pkg::MODE_SINE_INOUT; m <= eci_pkg::MODE_EXPO_INOUT; m += 3) begin
      d = '{32'sd1, -32'sd65536, 32'sd65536, 17'd65536, 4'(m)};
      send(d);
      d.progress = 17'd0;
      send(d);
    end
    d = '{32'sh7FFFFFFF, 32'sd0, 32'sh7FFFFFFF, 17'd100, eci_pkg::MODE_LINEAR};
    send(d);
    d = '{32'sh80000000, 32'sd3, 32'sh80000000, 17'h1FFFF, eci_pkg::MODE_CUBIC_IN};
    send(d);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1;
      d.start_value = pick_value();
      d.goal_value = pick_value();
      d.present_value = ($urandom_range(0, 15) == 0) ? d.goal_value : pick_value();
      d.progress = pick_progress();
      d.ease_mode = 4'($urandom_range(0, 15));
      send(d);
    end
    in_valid <= 1'b0;
    quiet = 1;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- easing_curve_interpolator.f -----
rtl/eci_pkg.sv
rtl/eci_front.sv
rtl/eci_queue.sv
rtl/eci_back.sv
rtl/easing_curve_interpolator.sv
bench/tb_top.sv
